[hdl/tpad_pkg.sv]
`timescale 1ns / 1ps
package tpad_pkg;

  localparam int TIMER_WIDTH_DEF = 8;

  localparam int LEVEL_W    = 8;
  localparam int PRESCALE_W = 8;
  localparam int DIV_W      = 9;
  localparam int PULSE_W    = 10;
  localparam int MODE_W     = 2;

  // apb register map
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_ON_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_OFF_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_PRESCALE_DIVIDE = 2'd2;
  localparam logic [1:0] REG_PULSE_TICKS     = 2'd3;

  // register reset values
  localparam logic [LEVEL_W-1:0] ON_THRESHOLD_RST    = 8'd210;
  localparam logic [LEVEL_W-1:0] OFF_THRESHOLD_RST   = 8'd10;
  localparam logic [DIV_W-1:0]   PRESCALE_DIVIDE_RST = 9'd32;
  localparam logic [PULSE_W-1:0] PULSE_TICKS_RST     = 10'd10;

  // output mode codes
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PHASE = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] on_threshold;
    logic [LEVEL_W-1:0] off_threshold;
    logic [DIV_W-1:0]   prescale_divide;
    logic [PULSE_W-1:0] pulse_ticks;
  } cfg_t;

endpackage

[hdl/tpad_cfg_regs.sv]
`timescale 1ns / 1ps
module tpad_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tpad_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tpad_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tpad_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output tpad_pkg::cfg_t                   cfg
);
  import tpad_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ON_THRESHOLD:    cfg_nxt.on_threshold    = pwdata[LEVEL_W-1:0];
        REG_OFF_THRESHOLD:   cfg_nxt.off_threshold   = pwdata[LEVEL_W-1:0];
        REG_PRESCALE_DIVIDE: cfg_nxt.prescale_divide = pwdata[DIV_W-1:0];
        REG_PULSE_TICKS:     cfg_nxt.pulse_ticks     = pwdata[PULSE_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_threshold    <= ON_THRESHOLD_RST;
      cfg_r.off_threshold   <= OFF_THRESHOLD_RST;
      cfg_r.prescale_divide <= PRESCALE_DIVIDE_RST;
      cfg_r.pulse_ticks     <= PULSE_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ON_THRESHOLD:    prdata = CFG_DATA_W'(cfg_r.on_threshold);
      REG_OFF_THRESHOLD:   prdata = CFG_DATA_W'(cfg_r.off_threshold);
      REG_PRESCALE_DIVIDE: prdata = CFG_DATA_W'(cfg_r.prescale_divide);
      REG_PULSE_TICKS:     prdata = CFG_DATA_W'(cfg_r.pulse_ticks);
      default:             prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[hdl/tpad_step.sv]
`timescale 1ns / 1ps
module tpad_step #(
  parameter int TIMER_WIDTH = tpad_pkg::TIMER_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          zero_cross,
  input  logic [tpad_pkg::LEVEL_W-1:0]  level,
  input  tpad_pkg::cfg_t                cfg,
  output logic                          gate,
  output logic [tpad_pkg::MODE_W-1:0]   mode
);
  import tpad_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [PRESCALE_W-1:0]  prescale_r, prescale_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic                   armed_r, armed_nxt;
  logic [PULSE_W-1:0]     pulse_r, pulse_nxt;
  logic                   pend_r, pend_nxt;
  logic                   gate_r, gate_nxt;

  logic [DIV_W-1:0]       div_eff;
  logic [DIV_W-1:0]       pre_inc;
  logic [PULSE_W-1:0]     pulse_eff;
  logic [PULSE_W-1:0]     pulse_dec;
  logic                   wrapped;
  logic                   lvl_on;
  logic                   lvl_off;

  always_comb begin
    // divide of zero counts every tick, anything past 256 saturates
    if (cfg.prescale_divide == '0) begin
      div_eff = DIV_W'(1);
    end else if (cfg.prescale_divide > DIV_W'(256)) begin
      div_eff = DIV_W'(256);
    end else begin
      div_eff = cfg.prescale_divide;
    end
    pulse_eff = (cfg.pulse_ticks == '0) ? PULSE_W'(1) : cfg.pulse_ticks;
    pre_inc   = {1'b0, prescale_r} + DIV_W'(1);
    pulse_dec = pulse_r - PULSE_W'(1);
    lvl_on    = (level >= cfg.on_threshold);
    lvl_off   = (level <= cfg.off_threshold);
  end

  always_comb begin
    prescale_nxt = prescale_r;
    timer_nxt    = timer_r;
    armed_nxt    = armed_r;
    pulse_nxt    = pulse_r;
    pend_nxt     = pend_r;
    gate_nxt     = gate_r;
    wrapped      = 1'b0;
    mode         = MODE_PHASE;

    // free-running prescaler and timer
    if (pre_inc >= div_eff) begin
      prescale_nxt = '0;
      if (timer_r == TIMER_MAX) begin
        timer_nxt = '0;
        wrapped   = 1'b1;
      end else begin
        timer_nxt = timer_r + TIMER_WIDTH'(1);
      end
    end else begin
      prescale_nxt = pre_inc[PRESCALE_W-1:0];
    end

    if (lvl_on || lvl_off) begin
      mode      = lvl_on ? MODE_ON : MODE_OFF;
      gate_nxt  = lvl_on;
      armed_nxt = 1'b0;
      pulse_nxt = '0;
      pend_nxt  = 1'b0;
    end else if (pulse_r != '0) begin
      pulse_nxt = pulse_dec;
      if (pulse_dec != '0) begin
        gate_nxt = 1'b1;
        if (zero_cross) pend_nxt = 1'b1;
      end else begin
        gate_nxt = 1'b0;
        if (zero_cross || pend_r) begin
          timer_nxt    = TIMER_WIDTH'(level);
          prescale_nxt = '0;
          armed_nxt    = 1'b1;
          pend_nxt     = 1'b0;
        end
      end
    end else if (zero_cross) begin
      gate_nxt     = 1'b0;
      timer_nxt    = TIMER_WIDTH'(level);
      prescale_nxt = '0;
      armed_nxt    = 1'b1;
      pend_nxt     = 1'b0;
    end else if (wrapped && armed_r) begin
      gate_nxt  = 1'b1;
      pulse_nxt = pulse_eff;
      armed_nxt = 1'b0;
    end
  end

  assign gate = gate_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
      timer_r    <= TIMER_MAX;
      armed_r    <= 1'b0;
      pulse_r    <= '0;
      pend_r     <= 1'b0;
      gate_r     <= 1'b0;
    end else if (en) begin
      prescale_r <= prescale_nxt;
      timer_r    <= timer_nxt;
      armed_r    <= armed_nxt;
      pulse_r    <= pulse_nxt;
      pend_r     <= pend_nxt;
      gate_r     <= gate_nxt;
    end
  end

  a_pulse_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    (pulse_r != '0) |-> !armed_r)
    else $error("armed while a gate pulse runs");

  a_pend_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (pulse_r != '0))
    else $error("pending crossing outside a gate pulse");

  a_forced_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (en && (mode != MODE_PHASE)) |=> (!armed_r && (pulse_r == '0) && !pend_r))
    else $error("forced mode left phase state behind");

endmodule

[hdl/triac_phase_angle_dimmer.sv]
`timescale 1ns / 1ps
// path: a tick transaction is held in the input register, then its result in the result register
// throughput: one tick transaction per clock cycle, sustained while out_tready stays high
// the input register refills in the cycle its tick moves on to the result register
// reset (rst_n low, synchronous): pipeline empty, timer all ones, prescaler, pulse,
// armed, pending crossing and gate cleared, registers back to 210 / 10 / 32 / 10
module triac_phase_angle_dimmer #(
  parameter int TIMER_WIDTH = tpad_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tick input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // [0] zero_cross, [8:1] level, rest zero
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [0] gate, [2:1] mode, rest zero
  // configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tpad_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tpad_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tpad_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import tpad_pkg::*;

  cfg_t               cfg;

  // input register
  logic               in_vld_r, in_vld_nxt;
  logic               in_cross_r;
  logic [LEVEL_W-1:0] in_level_r;

  // result register
  logic               out_vld_r, out_vld_nxt;
  logic               out_gate_r;
  logic [MODE_W-1:0]  out_mode_r;

  logic               step_gate;
  logic [MODE_W-1:0]  step_mode;
  logic               advance;
  logic               in_xfer;

  tpad_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // the held tick moves on when the result register is free or being drained
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  // one tick of the dimmer state per advance
  tpad_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .zero_cross (in_cross_r),
    .level      (in_level_r),
    .cfg        (cfg),
    .gate       (step_gate),
    .mode       (step_mode)
  );

  always_comb begin
    in_vld_nxt  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    out_vld_nxt = advance ? 1'b1 : ((out_vld_r && out_tready) ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_cross_r <= in_tdata[0];
      in_level_r <= in_tdata[8:1];
    end
    if (advance) begin
      out_gate_r <= step_gate;
      out_mode_r <= step_mode;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_mode_r, out_gate_r};

endmodule
